// ----- rtl/core/mlg_pkg.sv -----
package mlg_pkg;

  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_PLAYER_COUNT = 8;

  localparam int DIM_W     = 7;
  localparam int COORD_W   = 6;
  localparam int OWNER_W   = 3;
  localparam int TALLY_W   = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_READ  = 3'd2;
  localparam logic [2:0] KIND_STEP  = 3'd3;
  localparam logic [2:0] KIND_TALLY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT = 2'd1;

  localparam logic [TALLY_W-1:0] TALLY_MAX = 13'h1FFF;

  typedef struct packed {
    logic [2:0]         kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               alive_in;
    logic [OWNER_W-1:0] owner_in;
    logic [OWNER_W-1:0] player_sel;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               alive_out;
    logic [OWNER_W-1:0] owner_out;
    logic [TALLY_W-1:0] births_out;
    logic [TALLY_W-1:0] area_out;
    logic [TALLY_W-1:0] live_out;
    logic [TALLY_W-1:0] deaths_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_RD,
    S_GEN_RD,
    S_GEN_LAST,
    S_GEN_WR,
    S_GEN_TALLY
  } state_t;

endpackage

// ----- rtl/core/mlg_ifs.sv -----
interface mlg_in_if import mlg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface mlg_out_if import mlg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface mlg_cfg_if import mlg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/multiplayer_life_generation_core.sv -----
// Write, tally read and unknown kinds answer in the cycle after the beat; a cell read goes
//   via the RAM read register, then the output register in S_CELL_RD. Step: each interior
//   cell runs S_GEN_RD, S_GEN_LAST, S_GEN_WR and S_GEN_TALLY on the cell RAM (one read, one
//   write port); one item at a time. Clear: zeroes both pages, one RAM word per cycle.
// Reset: the same sweep runs after rst_n, no beat is taken until it ends;
//   config writes are taken at any time.
module multiplayer_life_generation_core import mlg_pkg::*; #(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
  parameter int PLAYER_COUNT = DEF_PLAYER_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  mlg_in_if.sink    in_ch,
  mlg_out_if.source out_ch,
  mlg_cfg_if.sink   cfg_ch
);

  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W    = 1 + RW + CW;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int PIDX_W    = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;
  localparam int CELL_W    = 1 + OWNER_W;
  localparam int CMP_W     = 12;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int m);
    if (v < DIM_W'(3)) return DIM_W'(3);
    else if (32'(v) > m) return DIM_W'(m);
    else return v;
  endfunction

  function automatic logic [PIDX_W-1:0] pidx(input logic [OWNER_W-1:0] o);
    logic [PIDX_W+OWNER_W-1:0] w;
    w = {{PIDX_W{1'b0}}, o};
    return (32'(o) >= PLAYER_COUNT) ? '0 : w[PIDX_W-1:0];
  endfunction

  function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] t);
    return (t == TALLY_MAX) ? t : t + TALLY_W'(1);
  endfunction

  function automatic logic [CW-1:0] col_of(input logic [COORD_W-1:0] c);
    logic [CW+COORD_W-1:0] w;
    w = {{CW{1'b0}}, c};
    return w[CW-1:0];
  endfunction

  function automatic logic [RW-1:0] row_of(input logic [COORD_W-1:0] r);
    logic [RW+COORD_W-1:0] w;
    w = {{RW{1'b0}}, r};
    return w[RW-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]   fw_r, fh_r;
  logic               page_r;
  logic [ADDR_W:0]    clr_r;
  logic               clr_item_r;
  logic [RW-1:0]      r_r;
  logic [CW-1:0]      c_r;
  logic [1:0]         dr_r, dc_r;
  logic               rd_v_r, rd_self_r;
  logic [3:0]         n_r;
  logic [OWNER_W-1:0] o_r [3];
  logic [CELL_W-1:0]  old_r, now_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic [TALLY_W-1:0] birth_r [PLAYER_COUNT];
  logic [TALLY_W-1:0] area_r  [PLAYER_COUNT];
  logic [TALLY_W-1:0] live_r  [PLAYER_COUNT];
  logic [TALLY_W-1:0] death_r [PLAYER_COUNT];

  logic [CELL_W-1:0] mem [MEM_DEPTH];
  logic [CELL_W-1:0] rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  logic in_fire, in_range, owner_ok, psel_ok, k_last, cell_last, row_last, gen_done;
  in_item_t itm;
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;
  logic [OWNER_W-1:0] major;
  logic [CELL_W-1:0]  gen_now;
  logic               gen_birth;

  assign itm      = in_ch.item;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_range = ({1'b0, itm.col} < fw_r) && ({1'b0, itm.row} < fh_r);
  assign owner_ok = 32'(itm.owner_in) < PLAYER_COUNT;
  assign psel_ok  = 32'(itm.player_sel) < PLAYER_COUNT;
  assign k_last   = (dr_r == 2'd2) && (dc_r == 2'd2);
  assign cell_last = !((CMP_W'(c_r) + CMP_W'(2)) < CMP_W'(fw_r));
  assign row_last  = !((CMP_W'(r_r) + CMP_W'(2)) < CMP_W'(fh_r));
  assign gen_done  = (state_r == S_GEN_TALLY) && cell_last && row_last;
  assign nb_row    = r_r + RW'(dr_r) - RW'(1);
  assign nb_col    = c_r + CW'(dc_r) - CW'(1);

  // majority of the three live neighbours, 0 when they all differ
  always_comb begin
    if (o_r[0] == o_r[1] || o_r[0] == o_r[2]) major = o_r[0];
    else if (o_r[1] == o_r[2])                major = o_r[1];
    else                                      major = '0;
  end

  always_comb begin
    gen_now   = old_r;
    gen_birth = 1'b0;
    if (n_r == 4'd3) begin
      if (!old_r[OWNER_W]) begin
        gen_birth = 1'b1;
        gen_now   = {1'b1, (major != '0) ? major : old_r[OWNER_W-1:0]};
      end
    end else if (n_r != 4'd2) begin
      gen_now = {1'b0, old_r[OWNER_W-1:0]};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (ADDR_W+1)'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (itm.kind)
            KIND_CLEAR: state_nxt = S_CLEAR;
            KIND_READ:  if (in_range) state_nxt = S_CELL_RD;
            KIND_STEP:  state_nxt = S_GEN_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CELL_RD:   state_nxt = S_IDLE;
      S_GEN_RD:    if (k_last) state_nxt = S_GEN_LAST;
      S_GEN_LAST:  state_nxt = S_GEN_WR;
      S_GEN_WR:    state_nxt = S_GEN_TALLY;
      S_GEN_TALLY: state_nxt = gen_done ? S_IDLE : S_GEN_RD;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = {page_r, row_of(itm.row), col_of(itm.col)};
    mem_wd      = {itm.alive_in, itm.owner_in};
    mem_ra      = {page_r, row_of(itm.row), col_of(itm.col)};
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r[ADDR_W-1:0];
        mem_wd = '0;
      end
      S_IDLE: begin
        in_ch.ready = !out_valid_r || out_ch.ready;
        mem_we      = in_fire && (itm.kind == KIND_WRITE) && in_range && owner_ok;
      end
      S_GEN_RD: mem_ra = {page_r, nb_row, nb_col};
      S_GEN_WR: begin
        mem_we = 1'b1;
        mem_wa = {~page_r, r_r, c_r};
        mem_wd = gen_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= clamp_dim(DIM_W'(64), MAX_WIDTH);
      fh_r <= clamp_dim(DIM_W'(64), MAX_HEIGHT);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FIELD_WIDTH:  fw_r <= clamp_dim(cfg_ch.data, MAX_WIDTH);
        CFG_FIELD_HEIGHT: fh_r <= clamp_dim(cfg_ch.data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_item_r  <= 1'b0;
      page_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      n_r         <= '0;
      for (int i = 0; i < PLAYER_COUNT; i++) begin
        birth_r[i] <= '0;
        area_r[i]  <= '0;
        live_r[i]  <= '0;
        death_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_GEN_RD);
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + (ADDR_W+1)'(1);
          if (state_nxt == S_IDLE) begin
            clr_item_r <= 1'b0;
            if (clr_item_r) begin
              out_valid_r <= 1'b1;
              out_item_r  <= '0;
            end
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            out_item_r <= '0;
            case (itm.kind)
              KIND_CLEAR: begin
                clr_r      <= '0;
                clr_item_r <= 1'b1;
                page_r     <= 1'b0;
              end
              KIND_WRITE: begin
                out_valid_r       <= 1'b1;
                out_item_r.status <= !(in_range && owner_ok);
              end
              KIND_READ: begin
                if (!in_range) begin
                  out_valid_r       <= 1'b1;
                  out_item_r.status <= 1'b1;
                end
              end
              KIND_STEP: begin
                r_r  <= RW'(1);
                c_r  <= CW'(1);
                dr_r <= '0;
                dc_r <= '0;
                n_r  <= '0;
              end
              KIND_TALLY: begin
                out_valid_r <= 1'b1;
                if (psel_ok) begin
                  out_item_r.births_out <= birth_r[pidx(itm.player_sel)];
                  out_item_r.area_out   <= area_r[pidx(itm.player_sel)];
                  out_item_r.live_out   <= live_r[pidx(itm.player_sel)];
                  out_item_r.deaths_out <= death_r[pidx(itm.player_sel)];
                end else begin
                  out_item_r.status <= 1'b1;
                end
              end
              default: out_valid_r <= 1'b1;
            endcase
            if (itm.kind == KIND_CLEAR || itm.kind == KIND_STEP) begin
              for (int i = 0; i < PLAYER_COUNT; i++) begin
                birth_r[i] <= '0;
                area_r[i]  <= '0;
                live_r[i]  <= '0;
                death_r[i] <= '0;
              end
            end
          end
        end
        S_CELL_RD: begin
          out_valid_r          <= 1'b1;
          out_item_r.alive_out <= rdata_r[OWNER_W];
          out_item_r.owner_out <= rdata_r[OWNER_W-1:0];
        end
        S_GEN_RD: begin
          rd_self_r <= (dr_r == 2'd1) && (dc_r == 2'd1);
          if (dc_r == 2'd2) begin
            dc_r <= '0;
            dr_r <= dr_r + 2'd1;
          end else begin
            dc_r <= dc_r + 2'd1;
          end
        end
        S_GEN_WR: begin
          now_r <= gen_now;
          if (gen_birth) birth_r[pidx(major)] <= bump(birth_r[pidx(major)]);
        end
        S_GEN_TALLY: begin
          if (n_r != 4'd2) begin
            area_r[pidx(now_r[OWNER_W-1:0])] <= bump(area_r[pidx(now_r[OWNER_W-1:0])]);
            if (now_r[OWNER_W])
              live_r[pidx(now_r[OWNER_W-1:0])] <= bump(live_r[pidx(now_r[OWNER_W-1:0])]);
            else if (old_r[OWNER_W])
              death_r[pidx(now_r[OWNER_W-1:0])] <= bump(death_r[pidx(now_r[OWNER_W-1:0])]);
          end
          dr_r <= '0;
          dc_r <= '0;
          n_r  <= '0;
          if (!cell_last) begin
            c_r <= c_r + CW'(1);
          end else begin
            c_r <= CW'(1);
            r_r <= r_r + RW'(1);
          end
          if (gen_done) begin
            page_r      <= ~page_r;
            out_valid_r <= 1'b1;
            out_item_r  <= '0;
          end
        end
        default: ;
      endcase

      // neighbour data lands in the cycle after its address
      if (rd_v_r) begin
        if (rd_self_r) begin
          old_r <= rdata_r;
        end else if (rdata_r[OWNER_W]) begin
          n_r <= n_r + 4'd1;
          if (n_r < 4'd3) o_r[n_r[1:0]] <= rdata_r[OWNER_W-1:0];
        end
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  a_we_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_GEN_WR || in_fire))
    else $error("cell RAM written outside clear, write beat or generation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 4'd8)
    else $error("neighbour count overran");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN_WR) |-> (r_r != '0 && c_r != '0))
    else $error("generation touched a border cell");

  a_page_swap: assert property (@(posedge clk) disable iff (!rst_n)
    gen_done |=> (page_r != $past(page_r)))
    else $error("pages not swapped at end of generation");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("beat taken while busy");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb import mlg_pkg::*; ;

  localparam int IDLE_LIMIT = 150000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS = 100;

  typedef struct {
    in_item_t  it;
    bit        known;
    out_item_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mlg_in_if  in_if ();
  mlg_out_if out_if ();
  mlg_cfg_if cfg_if ();

  multiplayer_life_generation_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the field: bit 3 alive, bits 2:0 owner
  logic [3:0]         field_cells [2][64][64];
  bit                 page;
  logic [TALLY_W-1:0] births [8];
  logic [TALLY_W-1:0] area [8];
  logic [TALLY_W-1:0] live [8];
  logic [TALLY_W-1:0] deaths [8];
  int                 fw = 64;
  int                 fh = 64;

  out_item_t pending_results [$];
  stim_row_t stim_rows [$];
  int        fails = 0;
  int        items_sent = 0;
  bit        src_no_idle = 0;
  bit        hold_req = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.item = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  function automatic logic [TALLY_W-1:0] sat_inc(logic [TALLY_W-1:0] x);
    return (x < TALLY_MAX) ? x + 1'b1 : x;
  endfunction

  function automatic void wipe_tallies();
    for (int p = 0; p < 8; p++) begin
      births[p] = '0; area[p] = '0; live[p] = '0; deaths[p] = '0;
    end
  endfunction

  function automatic void wipe_field();
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < 64; r++)
        for (int c = 0; c < 64; c++) field_cells[g][r][c] = '0;
    page = 0;
    wipe_tallies();
  endfunction

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic void evolve();
    int         n, major;
    int         hist [8];
    logic [3:0] old, now, v;
    logic [2:0] own;
    bit         nx;
    wipe_tallies();
    nx = ~page;
    for (int r = 1; r + 1 < fh; r++) begin
      for (int c = 1; c + 1 < fw; c++) begin
        for (int p = 0; p < 8; p++) hist[p] = 0;
        n = 0;
        major = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            v = field_cells[page][r+dr][c+dc];
            if (!v[3]) continue;
            n++;
            if (hist[v[2:0]] == 1) major = v[2:0];
            hist[v[2:0]]++;
          end
        old = field_cells[page][r][c];
        now = old;
        if (n == 2) begin
          field_cells[nx][r][c] = old;
          continue;
        end
        if (n == 3) begin
          if (!old[3]) begin
            now = {1'b1, old[2:0]};
            // majority of player 0 or no majority: owner kept
            if (major != 0) now = {1'b1, 3'(major)};
            births[major] = sat_inc(births[major]);
          end
        end else begin
          now = {1'b0, old[2:0]};
        end
        field_cells[nx][r][c] = now;
        own = now[2:0];
        area[own] = sat_inc(area[own]);
        if (now[3]) live[own] = sat_inc(live[own]);
        else if (old[3]) deaths[own] = sat_inc(deaths[own]);
      end
    end
    page = nx;
  endfunction

  function automatic out_item_t life_predict(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_CLEAR: wipe_field();
      KIND_WRITE, KIND_READ: begin
        if (it.col >= fw || it.row >= fh) begin
          r.status = 1'b1;
        end else if (it.kind == KIND_WRITE) begin
          field_cells[page][it.row][it.col] = {it.alive_in, it.owner_in};
        end else begin
          r.alive_out = field_cells[page][it.row][it.col][3];
          r.owner_out = field_cells[page][it.row][it.col][2:0];
        end
      end
      KIND_STEP: evolve();
      KIND_TALLY: begin
        r.births_out = births[it.player_sel];
        r.area_out = area[it.player_sel];
        r.live_out = live[it.player_sel];
        r.deaths_out = deaths[it.player_sel];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(logic [2:0] k, int col = 0, int row = 0,
                                  bit alive = 0, int owner = 0, int psel = 0);
    in_item_t it;
    it.kind = k;
    it.col = col[COORD_W-1:0];
    it.row = row[COORD_W-1:0];
    it.alive_in = alive;
    it.owner_in = owner[OWNER_W-1:0];
    it.player_sel = psel[OWNER_W-1:0];
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit known = 0, bit st = 0,
                                  bit al = 0, int ow = 0);
    stim_row_t s;
    s.it = it;
    s.known = known;
    s.res = '0;
    s.res.status = st;
    s.res.alive_out = al;
    s.res.owner_out = ow[OWNER_W-1:0];
    stim_rows.push_back(s);
  endfunction

  // called at a clock edge; valid is kept high across back-to-back beats
  task automatic send(in_item_t it, bit known = 0, out_item_t typed = '0);
    int gap;
    out_item_t p;
    gap = src_no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item <= it;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    p = life_predict(it);
    pending_results.push_back(known ? typed : p);
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_FIELD_WIDTH;
    cfg_if.data <= w;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    fw = clamp_dim(w);
    cfg_if.index <= CFG_FIELD_HEIGHT;
    cfg_if.data <= h;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    fh = clamp_dim(h);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic walk_rows();
    foreach (stim_rows[i]) send(stim_rows[i].it, stim_rows[i].known, stim_rows[i].res);
    stim_rows.delete();
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return DIM_W'($urandom_range(0, 2));
      1: return DIM_W'(64);
      2: return DIM_W'($urandom_range(65, 127));
      default: return DIM_W'($urandom_range(3, 14));
    endcase
  endfunction

  function automatic int pick_coord(int lim);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
  endfunction

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    bit no_stall;
    no_stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 29) == 0) no_stall = ~no_stall;
      stall = no_stall ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  function automatic void chk(string name, int e, int a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t e, a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.item;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = pending_results.pop_front();
        chk("status", e.status, a.status);
        chk("alive_out", e.alive_out, a.alive_out);
        chk("owner_out", e.owner_out, a.owner_out);
        chk("births_out", e.births_out, a.births_out);
        chk("area_out", e.area_out, a.area_out);
        chk("live_out", e.live_out, a.live_out);
        chk("deaths_out", e.deaths_out, a.deaths_out);
      end
    end
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    int quiet;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int nwr, nst, start;
    bit held;
    held = 0;
    wipe_field();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, default 64x64 field
    add_row(mk(KIND_READ, 0, 0), 1);
    add_row(mk(KIND_TALLY, 0, 0, 0, 0, 0), 1);
    add_row(mk(KIND_WRITE, 63, 63, 1, 7), 1);
    add_row(mk(KIND_READ, 63, 63), 1, 0, 1, 7);
    add_row(mk(3'd5, 63, 0, 1, 7, 7), 1);
    add_row(mk(3'd7, 0, 63, 1, 7, 7), 1);
    // blinker with owner 1 in majority
    add_row(mk(KIND_WRITE, 10, 9, 1, 1), 1);
    add_row(mk(KIND_WRITE, 10, 10, 1, 1), 1);
    add_row(mk(KIND_WRITE, 10, 11, 1, 2), 1);
    // three different owners: owner kept, birth goes to player 0
    add_row(mk(KIND_WRITE, 19, 20, 1, 3), 1);
    add_row(mk(KIND_WRITE, 20, 20, 1, 4), 1);
    add_row(mk(KIND_WRITE, 21, 20, 1, 5), 1);
    // majority held by player 0
    add_row(mk(KIND_WRITE, 29, 30, 1, 0), 1);
    add_row(mk(KIND_WRITE, 30, 30, 1, 0), 1);
    add_row(mk(KIND_WRITE, 31, 30, 1, 1), 1);
    add_row(mk(KIND_WRITE, 5, 0, 1, 6), 1);
    add_row(mk(KIND_STEP));
    add_row(mk(KIND_READ, 9, 10));
    add_row(mk(KIND_READ, 20, 19));
    add_row(mk(KIND_READ, 5, 0));
    add_row(mk(KIND_TALLY, 0, 0, 0, 0, 0));
    add_row(mk(KIND_TALLY, 0, 0, 0, 0, 1));
    add_row(mk(KIND_CLEAR), 1);
    add_row(mk(KIND_READ, 63, 63), 1);
    walk_rows();

    // width clamps to 3, height to 64
    drain();
    configure(7'd0, 7'd127);
    add_row(mk(KIND_WRITE, 3, 0, 1, 1), 1, 1);
    add_row(mk(KIND_READ, 2, 63), 1);
    walk_rows();
    drain();
    configure(7'd64, 7'd3);
    add_row(mk(KIND_READ, 0, 3), 1, 1);
    walk_rows();

    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      drain();
      configure(pick_dim(), pick_dim());
      src_no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) send(mk(KIND_CLEAR));
      if (!held && items_sent - start > 30) begin
        held = 1;
        hold_req = 1;
        repeat (4) send(mk(KIND_READ, pick_coord(fw), pick_coord(fh)));
      end
      nwr = $urandom_range(2, 14);
      repeat (nwr)
        send(mk(KIND_WRITE, pick_coord(fw), pick_coord(fh),
                $urandom_range(0, 3) != 0, $urandom_range(0, 7)));
      nst = $urandom_range(1, 3);
      repeat (nst) begin
        send(mk(KIND_STEP));
        repeat ($urandom_range(1, 3))
          send(mk(KIND_READ, pick_coord(fw), pick_coord(fh)));
        send(mk(KIND_TALLY, 0, 0, 0, 0, $urandom_range(0, 7)));
      end
      if ($urandom_range(0, 1)) send(in_item_t'($urandom));
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
